// ----- rtl/core/rpdr_pkg.sv -----
// Shared types and constants for the region pair dense relabel block.
package rpdr_pkg;

  localparam int unsigned LabelW  = 11;
  localparam int unsigned KeyW    = 21;
  localparam int unsigned RegionW = 12;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_OOR  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic load;
    logic fetch_rd;
    logic fetch_out;
    logic rank_init;
    logic scan;
    logic pass_end;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/rpdr_ctrl.sv -----
// Controller state machine for the region pair dense relabel block.
module rpdr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,
  input  logic          in_tlast,
  input  logic          out_tready,
  input  rpdr_pkg::sts_t sts,
  output rpdr_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_LAST  = 5'b01000,
    S_NEXT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE) && (!sts.out_busy || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser == rpdr_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
            if (in_tlast) begin
              cmd.rank_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end else begin
            cmd.fetch_rd = 1'b1;
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch_out = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_NEXT;
      S_NEXT: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.found ? S_SCAN : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rpdr_dp.sv -----
// Datapath for the region pair dense relabel block: stores, ranking passes, output register.
module rpdr_dp #(
  parameter int unsigned MAX_VERTICES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpdr_pkg::LabelW-1:0]    cfg_data,
  input  logic [39:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,
  input  rpdr_pkg::cmd_t                 cmd,
  output rpdr_pkg::sts_t                 sts
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned XW = (CW > rpdr_pkg::IndexW) ? CW : rpdr_pkg::IndexW;

  logic [rpdr_pkg::KeyW-1:0]     key_mem   [MAX_VERTICES];
  logic [rpdr_pkg::RegionW-1:0]  dense_mem [MAX_VERTICES];

  logic [rpdr_pkg::LabelW-1:0]   mc_r;
  logic [CW-1:0]                 count_r;
  logic                          closed_r;
  logic [AW-1:0]                 scan_r;
  logic                          rdv_r;
  logic [AW-1:0]                 rda_r;
  logic [rpdr_pkg::KeyW-1:0]     rdk_r;
  logic [rpdr_pkg::KeyW-1:0]     cur_r;
  logic                          cur_valid_r;
  logic [rpdr_pkg::KeyW-1:0]     min_r;
  logic                          found_r;
  logic [CW-1:0]                 rank_r;
  logic [rpdr_pkg::RegionW-1:0]  dense_rd_r;
  logic                          bad_r;
  logic                          ov_r;
  logic [rpdr_pkg::RegionW-1:0]  oreg_r;
  logic [rpdr_pkg::StatusW-1:0]  ost_r;

  logic [rpdr_pkg::LabelW-1:0]   asc, desc;
  logic [rpdr_pkg::IndexW-1:0]   vidx;
  logic [rpdr_pkg::KeyW-1:0]     key;
  logic                          full;
  logic [AW-1:0]                 wa;
  logic [XW-1:0]                 vx, cx;
  logic                          cand;

  assign asc  = in_tdata[10:0];
  assign desc = in_tdata[21:11];
  assign vidx = in_tdata[33:22];

  always_comb begin
    if (asc[10] || desc[10]) begin
      key = '0;
    end else begin
      key = rpdr_pkg::KeyW'(desc[9:0]) * rpdr_pkg::KeyW'(mc_r) + rpdr_pkg::KeyW'(asc[9:0])
            + rpdr_pkg::KeyW'(1);
    end
  end

  assign full = !closed_r && (count_r == CW'(MAX_VERTICES));
  assign wa   = closed_r ? '0 : count_r[AW-1:0];
  assign vx   = XW'(vidx);
  assign cx   = XW'(count_r);
  assign cand = rdv_r && (!cur_valid_r || rdk_r > cur_r) && (!found_r || rdk_r < min_r);

  assign sts.scan_end = (scan_r == AW'(count_r - CW'(1)));
  assign sts.found    = found_r;
  assign sts.out_busy = ov_r;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ost_r, oreg_r};

  always_ff @(posedge clk) begin
    if (cmd.load && !full) key_mem[wa] <= key;
    rdk_r <= key_mem[scan_r];
    rda_r <= scan_r;
    if (rdv_r && cur_valid_r && rdk_r == cur_r) begin
      dense_mem[rda_r] <= rank_r[rpdr_pkg::RegionW-1:0];
    end
    if (cmd.fetch_rd) dense_rd_r <= dense_mem[AW'(vidx)];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_rd) bad_r <= !closed_r || (vx >= cx);
    if (cmd.load) begin
      oreg_r <= '0;
      ost_r  <= full ? rpdr_pkg::ST_FULL : rpdr_pkg::ST_OK;
    end else if (cmd.fetch_out) begin
      oreg_r <= bad_r ? '0 : dense_rd_r;
      ost_r  <= bad_r ? rpdr_pkg::ST_OOR : rpdr_pkg::ST_OK;
    end
    if (cmd.rank_init || cmd.pass_end) begin
      min_r <= '0;
    end else if (cand) begin
      min_r <= rdk_r;
    end
    if (cmd.pass_end) cur_r <= min_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r        <= rpdr_pkg::LabelW'(1);
      count_r     <= '0;
      closed_r    <= 1'b0;
      scan_r      <= '0;
      rdv_r       <= 1'b0;
      cur_valid_r <= 1'b0;
      found_r     <= 1'b0;
      rank_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_valid) mc_r <= cfg_data;
      rdv_r <= cmd.scan;
      if (cmd.load) begin
        closed_r <= 1'b0;
        if (!full) count_r <= closed_r ? CW'(1) : count_r + CW'(1);
      end
      if (cmd.rank_init) begin
        scan_r      <= '0;
        cur_valid_r <= 1'b0;
        found_r     <= 1'b0;
        rank_r      <= '0;
      end else if (cmd.pass_end) begin
        scan_r      <= '0;
        found_r     <= 1'b0;
        cur_valid_r <= 1'b1;
        if (cur_valid_r) rank_r <= rank_r + CW'(1);
        if (!found_r) closed_r <= 1'b1;
      end else begin
        if (cmd.scan) scan_r <= scan_r + AW'(1);
        if (cand) found_r <= 1'b1;
      end
      if (cmd.load || cmd.fetch_out) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("loaded count beyond capacity");
  a_min_above_cur: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && cur_valid_r |-> min_r > cur_r)
    else $error("pass minimum not above current key");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load || cmd.fetch_rd) |-> !ov_r || out_tready)
    else $error("item taken while result held");
`endif

endmodule

// ----- rtl/core/region_pair_dense_relabel.sv -----
// Top level of the region pair dense relabel block.
// Usage:
//   in_*  : stream of load and fetch transactions. in_tuser is the operation
//           (0 load, 1 fetch), in_tlast marks the final load of a set.
//   out_* : one result transaction per input transaction, in order.
//   cfg_* : write of maxima_count, always ready; write only while idle.
// Result path: a load result is registered into the output register on acceptance; a fetch
//   first registers the read of the dense id memory, then the output register.
// Throughput: one load per cycle unless the output stalls; no input is taken in S_FETCH.
// A load with in_tlast starts ranking: (D + 1) passes over the N loaded vertices,
//   D distinct combined ids, one memory read per cycle.
//   No transaction is accepted during ranking.
// Reset clears the loaded count, the closed flag and sets maxima_count to 1;
//   store contents stay undefined until written.
// When out_tready is low the result holds in the output register and
//   in_tready stays low until it is taken.
module region_pair_dense_relabel #(
  parameter int unsigned MAX_VERTICES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // ascending_label, descending_label, vertex_index, zero fill
  input  logic        in_tuser,  // operation
  input  logic        in_tlast,  // last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // region_id, status, zero fill
);

  rpdr_pkg::cmd_t cmd;
  rpdr_pkg::sts_t sts;

  rpdr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpdr_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- tb/tb_region_pair_dense_relabel.sv -----
// Self-checking stream testbench for region_pair_dense_relabel, with a scoreboard predictor.
module tb_region_pair_dense_relabel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumVert = 4096;
  localparam longint unsigned CycleLimit = 3000000;

  class relabel_scoreboard;
    int unsigned combined_key [NumVert];
    int unsigned dense_rank [NumVert];
    int unsigned loaded;
    bit closed;
    int unsigned multiplier;
    int unsigned last_size;
    int unsigned last_distinct;
    logic [rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:0] pending [$];
    int unsigned mismatches;

    function new();
      loaded = 0;
      closed = 0;
      multiplier = 1;
      last_size = 0;
      last_distinct = 0;
      mismatches = 0;
    endfunction

    function void close_set();
      int unsigned keys [$];
      int unsigned uq [$];
      int unsigned r;
      for (int i = 0; i < loaded; i++) keys.insert(keys.size(), combined_key[i]);
      uq = keys.unique();
      for (int i = 0; i < loaded; i++) begin
        r = 0;
        foreach (uq[j]) if (uq[j] < combined_key[i]) r++;
        dense_rank[i] = r;
      end
      last_size = loaded;
      last_distinct = uq.size();
      closed = 1;
    endfunction

    function void note_input(logic op, logic [rpdr_pkg::LabelW-1:0] asc,
                             logic [rpdr_pkg::LabelW-1:0] desc,
                             logic last, logic [rpdr_pkg::IndexW-1:0] vidx);
      logic [rpdr_pkg::RegionW-1:0] region;
      logic [rpdr_pkg::StatusW-1:0] status;
      region = '0;
      status = rpdr_pkg::ST_OK;
      if (op == rpdr_pkg::OP_LOAD) begin
        if (closed) begin
          closed = 0;
          loaded = 0;
        end
        if (loaded >= NumVert) begin
          status = rpdr_pkg::ST_FULL;
        end else begin
          if (asc[rpdr_pkg::LabelW-1] || desc[rpdr_pkg::LabelW-1]) combined_key[loaded] = 0;
          else combined_key[loaded] = desc * multiplier + asc + 1;
          loaded++;
        end
        if (last) close_set();
      end else begin
        if (!closed || vidx >= loaded) status = rpdr_pkg::ST_OOR;
        else region = dense_rank[vidx][rpdr_pkg::RegionW-1:0];
      end
      pending.insert(pending.size(), {status, region});
    endfunction

    function void check_result(logic [15:0] data);
      logic [rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:0] exp_res;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected: %h", data);
        mismatches++;
        return;
      end
      exp_res = pending.pop_front();
      if (data[rpdr_pkg::RegionW-1:0] !== exp_res[rpdr_pkg::RegionW-1:0]) begin
        $error("region_id expected %0d actual %0d", exp_res[rpdr_pkg::RegionW-1:0],
               data[rpdr_pkg::RegionW-1:0]);
        mismatches++;
      end
      if (data[rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:rpdr_pkg::RegionW] !==
          exp_res[rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:rpdr_pkg::RegionW]) begin
        $error("status expected %0d actual %0d",
               exp_res[rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:rpdr_pkg::RegionW],
               data[rpdr_pkg::RegionW+rpdr_pkg::StatusW-1:rpdr_pkg::RegionW]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;  // ascending_label, descending_label, vertex_index, zero fill
  logic        in_tuser;  // operation
  logic        in_tlast;  // last_vertex
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata; // region_id, status, zero fill

  relabel_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  longint unsigned cycles;

  region_pair_dense_relabel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_item(logic op, logic [rpdr_pkg::LabelW-1:0] asc,
                           logic [rpdr_pkg::LabelW-1:0] desc,
                           logic last, logic [rpdr_pkg::IndexW-1:0] vidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {6'd0, vidx, desc, asc};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, asc, desc, last, vidx);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_pair(logic [rpdr_pkg::LabelW-1:0] asc, logic [rpdr_pkg::LabelW-1:0] desc,
                           logic last);
    send_item(rpdr_pkg::OP_LOAD, asc, desc, last, rpdr_pkg::IndexW'($urandom));
  endtask

  task automatic fetch_vertex(logic [rpdr_pkg::IndexW-1:0] vidx);
    send_item(rpdr_pkg::OP_FETCH, rpdr_pkg::LabelW'($urandom), rpdr_pkg::LabelW'($urandom),
              1'($urandom), vidx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat ((sb.last_size + 2) * (sb.last_distinct + 2) + 20) @(negedge clk);
  endtask

  task automatic write_multiplier(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.multiplier = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [rpdr_pkg::LabelW-1:0] pick_label();
    case ($urandom_range(9))
      0: return '1;
      1: return rpdr_pkg::LabelW'(11'h400 | $urandom_range(1023));
      2: return '0;
      3: return 11'd1023;
      4: return rpdr_pkg::LabelW'($urandom);
      default: return rpdr_pkg::LabelW'($urandom_range(5));
    endcase
  endfunction

  task automatic random_traffic(int unsigned count);
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        7: fetch_vertex(rpdr_pkg::IndexW'($urandom));
        8: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) load_pair(pick_label(), pick_label(), 1'b0);
          fetch_vertex(rpdr_pkg::IndexW'($urandom_range(3)));
        end
        9: load_pair(pick_label(), pick_label(), 1'($urandom));
        default: begin
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) load_pair(pick_label(), pick_label(), i == n - 1);
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) fetch_vertex(rpdr_pkg::IndexW'($urandom));
            else fetch_vertex(rpdr_pkg::IndexW'($urandom_range(sb.loaded + 1)));
          end
        end
      endcase
    end
  endtask

  task automatic directed_checks();
    fetch_vertex(12'd0);
    load_pair(11'd0, 11'd0, 1'b0);
    load_pair(11'd1023, 11'd1023, 1'b0);
    load_pair('1, 11'd5, 1'b0);
    load_pair(11'd5, '1, 1'b0);
    load_pair(11'h400, 11'd3, 1'b0);
    fetch_vertex(12'd0);
    load_pair(11'd3, 11'h400, 1'b0);
    load_pair(11'd1023, 11'd0, 1'b1);
    for (int i = 0; i < 8; i++) fetch_vertex(rpdr_pkg::IndexW'(i));
    fetch_vertex(12'hFFF);
    load_pair(11'd7, 11'd9, 1'b1);
    fetch_vertex(12'd0);
    fetch_vertex(12'd1);
  endtask

  initial begin
    logic [10:0] mult_values [6];
    sb = new();
    mult_values = '{11'd1, 11'd0, 11'd2047, 11'd1024, 11'($urandom), 11'd1024};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = rpdr_pkg::OP_LOAD;
    in_tlast = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p % 3 == 0) ? 33 : (p % 3 == 1) ? 70 : 0;
      recv_idle_pct = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 33 : 0;
      write_multiplier(mult_values[p]);
      if (p == 0) directed_checks();
      random_traffic(85);
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
rtl/core/rpdr_pkg.sv
rtl/core/rpdr_ctrl.sv
rtl/core/rpdr_dp.sv
rtl/core/region_pair_dense_relabel.sv
tb/tb_region_pair_dense_relabel.sv
